// ===== design/qs_pkg.sv =====
package qs_pkg;

    localparam int FRACTION_BITS_DEF = 14;

    // cosine and threshold width, Q28 with room for 1.0
    localparam int CW       = 29;
    // weight width, Q28
    localparam int WW       = 30;
    // square root working width
    localparam int VW       = 58;
    localparam int SQ_STEPS = 29;
    // quotient bits per division
    localparam int QB       = 30;
    // division remainder width
    localparam int DW       = 61;
    localparam int NCELLS   = 15;

    localparam logic [CW-1:0] ONE_Q28   = 29'h1000_0000;
    localparam logic [CW-1:0] THR_RESET = 29'd268432772;
    localparam logic [15:0]   T_ONE     = 16'h8000;

    typedef logic [3:0][15:0] t_quat;

    typedef struct packed {
        t_quat          a;
        t_quat          b;
        logic [15:0]    t;
        logic           neg;
        logic           lin;
        logic           tone;
        logic [CW-1:0]  cs;
        logic [WW-1:0]  lo1;
        logic [WW-1:0]  lo2;
        logic [WW-1:0]  hi1;
        logic [WW-1:0]  hi2;
    } t_item;

endpackage

// ===== design/qs_in_if.sv =====
interface qs_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] from_z;
    logic signed [15:0] from_w;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic signed [15:0] to_z;
    logic signed [15:0] to_w;
    logic        [15:0] fraction;

    modport source (
        output valid, from_x, from_y, from_z, from_w, to_x, to_y, to_z, to_w, fraction,
        input  ready
    );
    modport sink (
        input  valid, from_x, from_y, from_z, from_w, to_x, to_y, to_z, to_w, fraction,
        output ready
    );
endinterface

// ===== design/qs_out_if.sv =====
interface qs_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic signed [15:0] out_w;

    modport source (
        output valid, out_x, out_y, out_z, out_w,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, out_w,
        output ready
    );
endinterface

// ===== design/qs_front.sv =====
module qs_front #(
    parameter int FRACTION_BITS = qs_pkg::FRACTION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  qs_pkg::t_quat            i_a,
    input  qs_pkg::t_quat            i_b,
    input  logic [15:0]              i_t,
    input  logic [qs_pkg::CW-1:0]    i_thr,
    output logic                     o_valid,
    output qs_pkg::t_item            o_item
);
    localparam int SH_R = (2 * FRACTION_BITS > 28) ? 2 * FRACTION_BITS - 28 : 0;
    localparam int SH_L = (2 * FRACTION_BITS < 28) ? 28 - 2 * FRACTION_BITS : 0;
    localparam logic [63:0] RND = (64'd1 << SH_R) >> 1;

    logic                r_vld1;
    logic signed [31:0]  r_p [4];
    qs_pkg::t_quat       r_a1;
    qs_pkg::t_quat       r_b1;
    logic [15:0]         r_t1;
    logic signed [31:0]  n_p [4];
    logic [15:0]         n_t;

    logic                r_vld2;
    logic                r_neg;
    logic [32:0]         r_mag;
    qs_pkg::t_quat       r_a2;
    qs_pkg::t_quat       r_b2;
    logic [15:0]         r_t2;
    logic signed [33:0]  n_dot;
    logic [32:0]         n_mag;

    logic                r_vld3;
    qs_pkg::t_item       r_item;
    logic [63:0]         n_c64;
    logic [qs_pkg::CW-1:0] n_c;
    qs_pkg::t_item       n_item;

    // products, fraction clamp
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_p[k] = $signed(i_a[k]) * $signed(i_b[k]);
        end
        n_t = (i_t > qs_pkg::T_ONE) ? qs_pkg::T_ONE : i_t;
    end

    // dot sum and magnitude
    always_comb begin
        n_dot = 34'(r_p[0]) + 34'(r_p[1]) + 34'(r_p[2]) + 34'(r_p[3]);
        n_mag = n_dot[33] ? 33'(-n_dot) : 33'(n_dot);
    end

    // rescale to q28, clamp, branch choice
    always_comb begin
        n_c64 = ((64'(r_mag) + RND) >> SH_R) << SH_L;
        n_c   = (n_c64 > 64'(qs_pkg::ONE_Q28)) ? qs_pkg::ONE_Q28 : n_c64[qs_pkg::CW-1:0];
        n_item      = '0;
        n_item.a    = r_a2;
        n_item.b    = r_b2;
        n_item.t    = r_t2;
        n_item.neg  = r_neg;
        n_item.lin  = n_c > i_thr;
        n_item.tone = r_t2 == qs_pkg::T_ONE;
        n_item.cs   = n_c;
        n_item.lo1  = qs_pkg::WW'(qs_pkg::ONE_Q28);
        n_item.lo2  = '0;
        n_item.hi1  = '0;
        n_item.hi2  = qs_pkg::WW'(qs_pkg::ONE_Q28);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p    <= n_p;
            r_a1   <= i_a;
            r_b1   <= i_b;
            r_t1   <= n_t;
            r_neg  <= n_dot[33];
            r_mag  <= n_mag;
            r_a2   <= r_a1;
            r_b2   <= r_b1;
            r_t2   <= r_t1;
            r_item <= n_item;
        end
    end

    assign o_valid = r_vld3;
    assign o_item  = r_item;

endmodule

// ===== design/qs_cell.sv =====
module qs_cell #(
    parameter int BIT = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  qs_pkg::t_item i_item,
    output logic          o_valid,
    output qs_pkg::t_item o_item
);
    localparam int SQ = qs_pkg::SQ_STEPS;
    localparam int QB = qs_pkg::QB;
    localparam int VW = qs_pkg::VW;
    localparam int DW = qs_pkg::DW;
    localparam int CW = qs_pkg::CW;
    localparam int WW = qs_pkg::WW;

    // square root steps
    logic          w_sv [SQ+1];
    logic [VW-1:0] w_v  [SQ+1];
    logic [VW-1:0] w_r  [SQ+1];
    qs_pkg::t_item w_si [SQ+1];
    logic          r_sv [SQ];
    logic [VW-1:0] r_v  [SQ];
    logic [VW-1:0] r_r  [SQ];
    qs_pkg::t_item r_si [SQ];

    // rounding of the root, dividends
    logic          r_hv;
    logic [CW-1:0] r_h;
    logic [DW-1:0] r_n1;
    logic [DW-1:0] r_n2;
    qs_pkg::t_item r_hi;
    logic [CW-1:0] n_h;
    logic [DW-1:0] n_n1;
    logic [DW-1:0] n_n2;

    // division steps, two lanes sharing the divisor
    logic          w_dv   [QB+1];
    logic [CW-1:0] w_dh   [QB+1];
    logic [DW-1:0] w_rem1 [QB+1];
    logic [DW-1:0] w_rem2 [QB+1];
    logic [QB-1:0] w_q1   [QB+1];
    logic [QB-1:0] w_q2   [QB+1];
    qs_pkg::t_item w_di   [QB+1];
    logic          r_dv   [QB];
    logic [CW-1:0] r_dh   [QB];
    logic [DW-1:0] r_rem1 [QB];
    logic [DW-1:0] r_rem2 [QB];
    logic [QB-1:0] r_q1   [QB];
    logic [QB-1:0] r_q2   [QB];
    qs_pkg::t_item r_di   [QB];

    assign w_sv[0] = i_valid;
    assign w_v[0]  = VW'({1'b0, qs_pkg::ONE_Q28} + {1'b0, i_item.cs}) << 27;
    assign w_r[0]  = '0;
    assign w_si[0] = i_item;

    for (genvar j = 0; j < SQ; j++) begin : g_sq
        localparam logic [VW-1:0] SBIT = VW'(1) << (2 * (SQ - 1 - j));
        logic [VW-1:0] w_sum;
        logic          w_ge;

        assign w_sum = w_r[j] + SBIT;
        assign w_ge  = w_v[j] >= w_sum;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[j] <= 1'b0;
            end else if (i_en) begin
                r_sv[j] <= w_sv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[j]  <= w_ge ? w_v[j] - w_sum : w_v[j];
                r_r[j]  <= w_ge ? (w_r[j] >> 1) + SBIT : w_r[j] >> 1;
                r_si[j] <= w_si[j];
            end
        end

        assign w_sv[j+1] = r_sv[j];
        assign w_v[j+1]  = r_v[j];
        assign w_r[j+1]  = r_r[j];
        assign w_si[j+1] = r_si[j];
    end

    always_comb begin
        n_h  = CW'(w_r[SQ] + VW'(w_v[SQ] > w_r[SQ]));
        n_n1 = ((DW'(w_si[SQ].lo1) + DW'(w_si[SQ].hi1)) << 27) + DW'(n_h >> 1);
        n_n2 = ((DW'(w_si[SQ].lo2) + DW'(w_si[SQ].hi2)) << 27) + DW'(n_h >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
        end else if (i_en) begin
            r_hv <= w_sv[SQ];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h  <= n_h;
            r_n1 <= n_n1;
            r_n2 <= n_n2;
            r_hi <= w_si[SQ];
        end
    end

    assign w_dv[0]   = r_hv;
    assign w_dh[0]   = r_h;
    assign w_rem1[0] = r_n1;
    assign w_rem2[0] = r_n2;
    assign w_q1[0]   = '0;
    assign w_q2[0]   = '0;
    assign w_di[0]   = r_hi;

    for (genvar d = 0; d < QB; d++) begin : g_div
        localparam int POS = QB - 1 - d;
        logic [DW-1:0] w_den;
        logic          w_ge1;
        logic          w_ge2;

        assign w_den = DW'(w_dh[d]) << POS;
        assign w_ge1 = w_rem1[d] >= w_den;
        assign w_ge2 = w_rem2[d] >= w_den;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[d] <= 1'b0;
            end else if (i_en) begin
                r_dv[d] <= w_dv[d];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dh[d]   <= w_dh[d];
                r_rem1[d] <= w_ge1 ? w_rem1[d] - w_den : w_rem1[d];
                r_rem2[d] <= w_ge2 ? w_rem2[d] - w_den : w_rem2[d];
                r_q1[d]   <= w_q1[d] | (QB'(w_ge1) << POS);
                r_q2[d]   <= w_q2[d] | (QB'(w_ge2) << POS);
                r_di[d]   <= w_di[d];
            end
        end

        assign w_dv[d+1]   = r_dv[d];
        assign w_dh[d+1]   = r_dh[d];
        assign w_rem1[d+1] = r_rem1[d];
        assign w_rem2[d+1] = r_rem2[d];
        assign w_q1[d+1]   = r_q1[d];
        assign w_q2[d+1]   = r_q2[d];
        assign w_di[d+1]   = r_di[d];
    end

    // keep the half of the arc that the fraction bit selects
    always_comb begin
        o_item    = w_di[QB];
        o_item.cs = w_dh[QB];
        if (w_di[QB].t[BIT]) begin
            o_item.lo1 = WW'(w_q1[QB]);
            o_item.lo2 = WW'(w_q2[QB]);
        end else begin
            o_item.hi1 = WW'(w_q1[QB]);
            o_item.hi2 = WW'(w_q2[QB]);
        end
    end

    assign o_valid = w_dv[QB];

endmodule

// ===== design/qs_back.sv =====
module qs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  qs_pkg::t_item i_item,
    output logic          o_valid,
    output qs_pkg::t_quat o_q
);
    localparam int WW = qs_pkg::WW;

    logic                r_vld1;
    logic [WW-1:0]       r_w1;
    logic [WW-1:0]       r_w2;
    qs_pkg::t_quat       r_a;
    qs_pkg::t_quat       r_b;
    logic                r_neg1;
    logic [WW-1:0]       n_w1;
    logic [WW-1:0]       n_w2;

    logic                r_vld2;
    logic signed [46:0]  r_pa [4];
    logic signed [46:0]  r_pb [4];
    logic                r_neg2;
    logic signed [46:0]  n_pa [4];
    logic signed [46:0]  n_pb [4];

    logic                r_vld3;
    qs_pkg::t_quat       r_q;
    qs_pkg::t_quat       n_q;

    // weight select
    always_comb begin
        if (i_item.lin) begin
            n_w1 = WW'(qs_pkg::T_ONE - i_item.t) << 13;
            n_w2 = WW'(i_item.t) << 13;
        end else if (i_item.tone) begin
            n_w1 = '0;
            n_w2 = WW'(qs_pkg::ONE_Q28);
        end else begin
            n_w1 = i_item.lo1;
            n_w2 = i_item.lo2;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_pa[k] = $signed(r_a[k]) * $signed({1'b0, r_w1});
            n_pb[k] = $signed(r_b[k]) * $signed({1'b0, r_w2});
        end
    end

    // sum, round half up, saturate
    always_comb begin
        logic signed [47:0] s;
        logic signed [47:0] q;
        for (int k = 0; k < 4; k++) begin
            s = 48'(r_pa[k]) + (r_neg2 ? -48'(r_pb[k]) : 48'(r_pb[k]));
            q = (s + 48'sd134217728) >>> 28;
            if (q > 48'sd32767) begin
                n_q[k] = 16'h7fff;
            end else if (q < -48'sd32768) begin
                n_q[k] = 16'h8000;
            end else begin
                n_q[k] = q[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w1   <= n_w1;
            r_w2   <= n_w2;
            r_a    <= i_item.a;
            r_b    <= i_item.b;
            r_neg1 <= i_item.neg;
            r_pa   <= n_pa;
            r_pb   <= n_pb;
            r_neg2 <= r_neg1;
            r_q    <= n_q;
        end
    end

    assign o_valid = r_vld3;
    assign o_q     = r_q;

endmodule

// ===== design/quaternion_slerp.sv =====
// channel   dir  handshake     payload
// i_item    in   valid/ready   from_x..from_w, to_x..to_w, fraction
// o_item    out  valid/ready   out_x, out_y, out_z, out_w
// i_cfg     in   i_cfg_we      i_cfg_data = lerp_threshold
//
// one item per cycle while o_item is not stalled; 3 dot stages, 15 bisection cells of
// 60 stages each (29 root steps, 1 rounding stage, 30 divider steps), 3 output stages
// reset clears all valid bits and loads the threshold with 1 - 0.00001
// a result held on o_item stalls the whole pipe; i_item.ready is low only then
module quaternion_slerp #(
    parameter int FRACTION_BITS = qs_pkg::FRACTION_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    qs_in_if.sink                 i_item,
    qs_out_if.source              o_item,
    input  logic                  i_cfg_we,
    input  logic [qs_pkg::CW-1:0] i_cfg_data
);
    localparam int NC = qs_pkg::NCELLS;

    logic                  r_thr;
    logic [qs_pkg::CW-1:0] r_thr_val;
    logic                  w_en;
    logic                  w_fv;
    qs_pkg::t_quat         w_a;
    qs_pkg::t_quat         w_b;
    logic                  w_cv [NC+1];
    qs_pkg::t_item         w_ci [NC+1];
    logic                  w_ov;
    qs_pkg::t_quat         w_oq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= 1'b0;
            r_thr_val <= qs_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr     <= 1'b1;
            r_thr_val <= i_cfg_data;
        end
    end

    assign w_en         = !w_ov || o_item.ready;
    assign i_item.ready = w_en;

    assign w_a = {i_item.from_w, i_item.from_z, i_item.from_y, i_item.from_x};
    assign w_b = {i_item.to_w, i_item.to_z, i_item.to_y, i_item.to_x};

    qs_front #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_item.valid),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_t     (i_item.fraction),
        .i_thr   (r_thr_val),
        .o_valid (w_fv),
        .o_item  (w_ci[0])
    );

    assign w_cv[0] = w_fv;

    // most significant fraction bit first
    for (genvar n = 0; n < NC; n++) begin : g_cell
        qs_cell #(
            .BIT(NC - 1 - n)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_cv[n]),
            .i_item  (w_ci[n]),
            .o_valid (w_cv[n+1]),
            .o_item  (w_ci[n+1])
        );
    end

    qs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cv[NC]),
        .i_item  (w_ci[NC]),
        .o_valid (w_ov),
        .o_q     (w_oq)
    );

    assign o_item.valid = w_ov;
    assign o_item.out_x = w_oq[0];
    assign o_item.out_y = w_oq[1];
    assign o_item.out_z = w_oq[2];
    assign o_item.out_w = w_oq[3];

`ifndef SYNTH
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_item.valid && !o_item.ready) |-> !i_item.ready)
        else $error("input accepted while output stalled");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_item.valid)
        else $error("output valid after reset");

    a_stall_holds_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_item.valid && !o_item.ready) |=> $stable(w_fv))
        else $error("front end moved during stall");

    a_cfg_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_thr && r_thr_val == $past(i_cfg_data)))
        else $error("threshold write lost");
`endif

endmodule

// ===== sim/slerp_checker.sv =====
`timescale 1ns / 1ps

module slerp_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    qs_in_if.sink        i_item,
    qs_out_if.sink       o_item,
    input  logic         i_cfg_we,
    input  logic [28:0]  i_cfg_data,
    output int           o_errors,
    output int           o_pending
);
    typedef struct {
        logic signed [15:0] x, y, z, w;
    } t_rot;

    t_rot        expected_rots[$];
    logic [28:0] threshold;
    int          errors;

    assign o_errors  = errors;
    assign o_pending = expected_rots.size();

    function automatic logic [63:0] isqrt_near(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        if (v > r) r = r + 1;
        return r;
    endfunction

    function automatic logic signed [15:0] scale_sat(input longint s);
        longint r;
        longint q;
        r = s + (longint'(1) << 27);
        if (r >= 0) q = r >>> 28;
        else q = -((-r + (longint'(1) << 28) - 1) >>> 28);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic t_rot slerp_predict(input qs_pkg::t_quat qa, input qs_pkg::t_quat qb,
                                           input logic [15:0] frac);
        longint      a[4];
        longint      b[4];
        longint      dot;
        logic [63:0] mag, c, t, w1, w2, lo1, lo2, hi1, hi2, cs, h, m1, m2;
        logic        neg;
        longint      s2;
        t_rot        res;
        logic signed [15:0] o[4];
        dot = 0;
        for (int k = 0; k < 4; k++) begin
            a[k] = longint'($signed(qa[k]));
            b[k] = longint'($signed(qb[k]));
            dot += a[k] * b[k];
        end
        t = frac;
        if (t > 32768) t = 32768;
        neg = dot < 0;
        mag = neg ? -dot : dot;
        c = mag;
        if (c > (64'd1 << 28)) c = 64'd1 << 28;
        if (c > threshold) begin
            w1 = (32768 - t) << 13;
            w2 = t << 13;
        end else if (t == 32768) begin
            w1 = 0;
            w2 = 64'd1 << 28;
        end else begin
            lo1 = 64'd1 << 28; lo2 = 0; hi1 = 0; hi2 = 64'd1 << 28;
            cs = c;
            for (int i = 14; i >= 0; i--) begin
                h  = isqrt_near(((64'd1 << 28) + cs) << 27);
                m1 = (((lo1 + hi1) << 27) + (h >> 1)) / h;
                m2 = (((lo2 + hi2) << 27) + (h >> 1)) / h;
                if (t[i]) begin
                    lo1 = m1; lo2 = m2;
                end else begin
                    hi1 = m1; hi2 = m2;
                end
                cs = h;
            end
            w1 = lo1;
            w2 = lo2;
        end
        for (int k = 0; k < 4; k++) begin
            s2 = b[k] * longint'(w2);
            o[k] = scale_sat(a[k] * longint'(w1) + (neg ? -s2 : s2));
        end
        res.x = o[0]; res.y = o[1]; res.z = o[2]; res.w = o[3];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_rot          e;
        qs_pkg::t_quat qa;
        qs_pkg::t_quat qb;
        int            nerr;
        nerr = 0;
        if (!i_rst_n) begin
            threshold <= qs_pkg::THR_RESET;
            errors    <= 0;
            expected_rots.delete();
        end else begin
            if (i_cfg_we) threshold <= i_cfg_data;
            if (i_item.valid && i_item.ready) begin
                qa = {i_item.from_w, i_item.from_z, i_item.from_y, i_item.from_x};
                qb = {i_item.to_w, i_item.to_z, i_item.to_y, i_item.to_x};
                expected_rots.push_back(slerp_predict(qa, qb, i_item.fraction));
            end
            if (o_item.valid && o_item.ready) begin
                if (expected_rots.size() == 0) begin
                    $error("unexpected item out");
                    nerr = nerr + 1;
                end else begin
                    e = expected_rots.pop_front();
                    if (o_item.out_x !== e.x) begin
                        $error("out_x expected %0d actual %0d", e.x, o_item.out_x);
                        nerr = nerr + 1;
                    end
                    if (o_item.out_y !== e.y) begin
                        $error("out_y expected %0d actual %0d", e.y, o_item.out_y);
                        nerr = nerr + 1;
                    end
                    if (o_item.out_z !== e.z) begin
                        $error("out_z expected %0d actual %0d", e.z, o_item.out_z);
                        nerr = nerr + 1;
                    end
                    if (o_item.out_w !== e.w) begin
                        $error("out_w expected %0d actual %0d", e.w, o_item.out_w);
                        nerr = nerr + 1;
                    end
                end
            end
            errors <= errors + nerr;
        end
    end
endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        cfg_we = 0;
    logic [28:0] cfg_data = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          errors;
    int          pending;

    qs_in_if  in_ch();
    qs_out_if out_ch();

    always #10 i_clk = ~i_clk;

    quaternion_slerp u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (in_ch.sink),
        .o_item     (out_ch.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    slerp_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (in_ch.sink),
        .o_item     (out_ch.sink),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        in_ch.valid    = 0;
        in_ch.from_x   = 0;
        in_ch.from_y   = 0;
        in_ch.from_z   = 0;
        in_ch.from_w   = 0;
        in_ch.to_x     = 0;
        in_ch.to_y     = 0;
        in_ch.to_z     = 0;
        in_ch.to_w     = 0;
        in_ch.fraction = 0;
        out_ch.ready   = 0;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_rot(input logic [15:0] fx, fy, fz, fw, tx, ty, tz, tw, fr);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid    <= 1;
        in_ch.from_x   <= fx;
        in_ch.from_y   <= fy;
        in_ch.from_z   <= fz;
        in_ch.from_w   <= fw;
        in_ch.to_x     <= tx;
        in_ch.to_y     <= ty;
        in_ch.to_z     <= tz;
        in_ch.to_w     <= tw;
        in_ch.fraction <= fr;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain_all();
        in_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [28:0] v);
        cfg_we   <= 1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we   <= 0;
    endtask

    function automatic logic [15:0] rand_frac();
        int p;
        p = $urandom_range(9);
        if (p == 0) return 16'($urandom_range(65535));
        if (p == 1) return 16'h8000;
        if (p == 2) return 16'h0000;
        return 16'($urandom_range(32767));
    endfunction

    // random pair; mode 1 makes a nearly parallel pair: to = +/- from plus small noise
    task automatic send_random();
        logic [15:0] f[4];
        logic [15:0] g[4];
        int          mode;
        int          s;
        mode = $urandom_range(3);
        s = $urandom_range(1) ? 1 : -1;
        for (int k = 0; k < 4; k++) begin
            f[k] = (mode == 0) ? 16'($urandom_range(65535))
                               : 16'(int'($urandom_range(16384)) - 8192);
            if (mode == 1) g[k] = 16'(s * $signed(f[k]) + int'($urandom_range(6)) - 3);
            else g[k] = (mode == 0) ? 16'($urandom_range(65535))
                                    : 16'(int'($urandom_range(16384)) - 8192);
        end
        send_rot(f[0], f[1], f[2], f[3], g[0], g[1], g[2], g[3], rand_frac());
    endtask

    initial begin
        #2_000_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [28:0] thresholds[4];
        thresholds = '{29'd268432772, 29'd0, 29'd268435456, 29'h1FFF_FFFF};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, exact one, parallel, opposite, tiny negative dot
        send_rot(16'h4000, 0, 0, 0, 16'h4000, 0, 0, 0, 16'h4000);
        send_rot(16'h4000, 0, 0, 0, 0, 16'h4000, 0, 0, 16'h4000);
        send_rot(16'h4000, 0, 0, 0, 16'hC000, 0, 0, 0, 16'h2000);
        send_rot(16'h4000, 0, 0, 0, 0, 16'h4000, 0, 0, 16'h8000);
        send_rot(16'h4000, 0, 0, 0, 0, 16'h4000, 0, 0, 16'hFFFF);
        send_rot(16'h4000, 0, 0, 0, 0, 16'h4000, 0, 0, 0);
        send_rot(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h4000);
        send_rot(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h1234);
        send_rot(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001);
        send_rot(16'h0001, 0, 0, 0, 16'hFFFF, 0, 0, 0, 16'h5555);
        send_rot(0, 0, 0, 0, 0, 0, 0, 0, 16'h2AAA);
        send_rot(16'h2D41, 16'h2D41, 0, 0, 16'h2D41, 16'h2D40, 0, 0, 16'h7FFF);
        drain_all();

        for (int ph = 0; ph < 4; ph++) begin
            write_threshold(thresholds[ph]);
            for (int n = 0; n < 425; n++) begin
                if (n < 140) begin
                    send_idle_pct = 25; recv_idle_pct = 80;
                end else if (n < 280) begin
                    send_idle_pct = 80; recv_idle_pct = 25;
                end else begin
                    send_idle_pct = 0; recv_idle_pct = 0;
                end
                if (n == 200) drain_all();
                send_random();
            end
            drain_all();
        end

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
